/* rtl/xbee_api_frame_packer_macros.svh */
// assertion macros for the frame packer
`ifndef XBEE_API_FRAME_PACKER_MACROS_SVH
`define XBEE_API_FRAME_PACKER_MACROS_SVH

// property must hold at every clock edge outside reset
`define XAFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define XAFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/xafp_pkg.sv */
// ----------------------------------------------------------------------------
// xafp_pkg
// types, constants and commands shared by the frame packer modules
// ----------------------------------------------------------------------------
package xafp_pkg;

  localparam int unsigned PayloadBytesDef   = 64;
  localparam int unsigned BytesPerResultDef = 8;

  localparam logic [7:0] StartDelim = 8'h7e;
  localparam logic [7:0] EscapeMark = 8'h7d;
  localparam logic [7:0] TxRequest  = 8'h10;
  localparam logic [7:0] EscXor     = 8'h20;
  localparam int unsigned OptBytes  = 14;

  localparam logic [2:0] RegFrameId   = 3'd0;
  localparam logic [2:0] RegAddr64    = 3'd1;
  localparam logic [2:0] RegAddr16    = 3'd2;
  localparam logic [2:0] RegRadius    = 3'd3;
  localparam logic [2:0] RegTxOpts    = 3'd4;
  localparam logic [2:0] RegTimeout   = 3'd5;
  localparam logic [2:0] RegThreshold = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELIM,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_OPTS,
    ST_PAY_RD,
    ST_PAY,
    ST_PAY_ESC,
    ST_CSUM,
    ST_DRAIN
  } state_e;

  // what to do after the current frame is out
  typedef enum logic [1:0] {
    AFT_NONE,
    AFT_STORE,
    AFT_CLR_TICKS
  } after_e;

  typedef struct packed {
    logic       clr_frame;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       sum_add;
    logic       opt_step;
    logic       pay_rd;
    logic       pay_step;
  } cmd_t;

  typedef struct packed {
    logic       opt_done;
    logic       pay_done;
    logic       pay_esc;
    logic [7:0] pay_byte;
    logic [7:0] opt_byte;
    logic [7:0] csum;
    logic       pack_busy;
  } sts_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == 8'h7e) || (b == 8'h7d) || (b == 8'h11) || (b == 8'h13);
  endfunction

endpackage

/* rtl/xafp_ctrl.sv */
// ----------------------------------------------------------------------------
// xafp_ctrl
// frame serialising state machine: walks header, options, payload, checksum
// ----------------------------------------------------------------------------
module xafp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [7:0]        len_hi_i,
  input  logic [7:0]        len_lo_i,
  input  xafp_pkg::sts_t    sts_i,
  output xafp_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  xafp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xafp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      xafp_pkg::ST_IDLE:   if (start_i) state_d = xafp_pkg::ST_DELIM;
      xafp_pkg::ST_DELIM:  if (!sts_i.pack_busy) state_d = xafp_pkg::ST_LEN_HI;
      xafp_pkg::ST_LEN_HI: if (!sts_i.pack_busy) state_d = xafp_pkg::ST_LEN_LO;
      xafp_pkg::ST_LEN_LO: if (!sts_i.pack_busy) state_d = xafp_pkg::ST_OPTS;
      xafp_pkg::ST_OPTS: begin
        if (!sts_i.pack_busy && sts_i.opt_done) state_d = xafp_pkg::ST_PAY_RD;
      end
      xafp_pkg::ST_PAY_RD: begin
        state_d = sts_i.pay_done ? xafp_pkg::ST_CSUM : xafp_pkg::ST_PAY;
      end
      xafp_pkg::ST_PAY: begin
        if (!sts_i.pack_busy) begin
          state_d = sts_i.pay_esc ? xafp_pkg::ST_PAY_ESC : xafp_pkg::ST_PAY_RD;
        end
      end
      xafp_pkg::ST_PAY_ESC: if (!sts_i.pack_busy) state_d = xafp_pkg::ST_PAY_RD;
      xafp_pkg::ST_CSUM:   if (!sts_i.pack_busy) state_d = xafp_pkg::ST_DRAIN;
      xafp_pkg::ST_DRAIN:  if (!sts_i.pack_busy) state_d = xafp_pkg::ST_IDLE;
      default:             state_d = xafp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    busy_o   = (state_q != xafp_pkg::ST_IDLE);
    done_o   = (state_q == xafp_pkg::ST_DRAIN) && !sts_i.pack_busy;
    case (state_q)
      xafp_pkg::ST_IDLE: cmd_o.clr_frame = start_i;
      xafp_pkg::ST_DELIM: begin
        cmd_o.emit      = !sts_i.pack_busy;
        cmd_o.emit_byte = xafp_pkg::StartDelim;
      end
      xafp_pkg::ST_LEN_HI: begin
        cmd_o.emit      = !sts_i.pack_busy;
        cmd_o.emit_byte = len_hi_i;
      end
      xafp_pkg::ST_LEN_LO: begin
        cmd_o.emit      = !sts_i.pack_busy;
        cmd_o.emit_byte = len_lo_i;
      end
      xafp_pkg::ST_OPTS: begin
        cmd_o.emit      = !sts_i.pack_busy;
        cmd_o.emit_byte = sts_i.opt_byte;
        cmd_o.sum_add   = !sts_i.pack_busy;
        cmd_o.opt_step  = !sts_i.pack_busy;
      end
      xafp_pkg::ST_PAY_RD: cmd_o.pay_rd = 1'b1;
      xafp_pkg::ST_PAY: begin
        cmd_o.emit      = !sts_i.pack_busy;
        cmd_o.emit_byte = sts_i.pay_esc ? xafp_pkg::EscapeMark : sts_i.pay_byte;
        cmd_o.sum_add   = !sts_i.pack_busy;
        cmd_o.pay_step  = !sts_i.pack_busy;
      end
      xafp_pkg::ST_PAY_ESC: begin
        cmd_o.emit      = !sts_i.pack_busy;
        cmd_o.emit_byte = sts_i.pay_byte ^ xafp_pkg::EscXor;
      end
      xafp_pkg::ST_CSUM: begin
        cmd_o.emit      = !sts_i.pack_busy;
        cmd_o.emit_byte = 8'hff - sts_i.csum;
        cmd_o.emit_last = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/xafp_datapath.sv */
// ----------------------------------------------------------------------------
// xafp_datapath
// payload memory, option byte mux, checksum and output packer
// ----------------------------------------------------------------------------
module xafp_datapath #(
  parameter int unsigned PayloadBytes   = xafp_pkg::PayloadBytesDef,
  parameter int unsigned BytesPerResult = xafp_pkg::BytesPerResultDef,
  localparam int unsigned AW = $clog2(PayloadBytes),
  localparam int unsigned CW = $clog2(PayloadBytes + 1),
  localparam int unsigned PW = $clog2(BytesPerResult + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // payload memory write
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic [CW-1:0]     fill_i,
  // option fields
  input  logic [7:0]        frame_id_i,
  input  logic [63:0]       addr64_i,
  input  logic [15:0]       addr16_i,
  input  logic [7:0]        radius_i,
  input  logic [7:0]        txopts_i,
  input  xafp_pkg::cmd_t    cmd_i,
  output xafp_pkg::sts_t    sts_o,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [63:0]       frame_bytes_o,
  output logic [3:0]        byte_count_o,
  output logic              last_of_frame_o
);

  logic [7:0] mem_q [PayloadBytes];
  logic [7:0] rd_q;
  logic [AW:0] rd_idx_q;
  logic [3:0] opt_idx_q;
  logic [7:0] sum_q;
  logic [BytesPerResult*8-1:0] acc_q;
  logic [PW-1:0] cnt_q;
  logic out_v_q;
  logic [63:0] ob_q;
  logic [3:0] oc_q;
  logic ol_q;
  logic [7:0] opt_byte;
  logic [7:0] add_byte;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (cmd_i.pay_rd && (rd_idx_q < (AW+1)'(PayloadBytes))) begin
      rd_q <= mem_q[rd_idx_q[AW-1:0]];
    end
  end

  always_comb begin
    case (opt_idx_q)
      4'd0:    opt_byte = xafp_pkg::TxRequest;
      4'd1:    opt_byte = frame_id_i;
      4'd2:    opt_byte = addr64_i[63:56];
      4'd3:    opt_byte = addr64_i[55:48];
      4'd4:    opt_byte = addr64_i[47:40];
      4'd5:    opt_byte = addr64_i[39:32];
      4'd6:    opt_byte = addr64_i[31:24];
      4'd7:    opt_byte = addr64_i[23:16];
      4'd8:    opt_byte = addr64_i[15:8];
      4'd9:    opt_byte = addr64_i[7:0];
      4'd10:   opt_byte = addr16_i[15:8];
      4'd11:   opt_byte = addr16_i[7:0];
      4'd12:   opt_byte = radius_i;
      default: opt_byte = txopts_i;
    endcase
  end

  assign add_byte = cmd_i.pay_step ? rd_q : opt_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      opt_idx_q <= '0;
      sum_q     <= '0;
      acc_q     <= '0;
      cnt_q     <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      if (cmd_i.clr_frame) begin
        rd_idx_q  <= '0;
        opt_idx_q <= '0;
        sum_q     <= '0;
        acc_q     <= '0;
        cnt_q     <= '0;
      end
      if (cmd_i.opt_step) opt_idx_q <= opt_idx_q + 4'd1;
      if (cmd_i.pay_step) rd_idx_q <= rd_idx_q + (AW+1)'(1);
      if (cmd_i.sum_add) sum_q <= sum_q + add_byte;
      if (cmd_i.emit) begin
        if ((cnt_q == PW'(BytesPerResult - 1)) || cmd_i.emit_last) begin
          out_v_q <= 1'b1;
          ob_q    <= 64'(acc_q | ((BytesPerResult*8)'(cmd_i.emit_byte) << (cnt_q * 8)));
          oc_q    <= 4'(cnt_q) + 4'd1;
          ol_q    <= cmd_i.emit_last;
          acc_q   <= '0;
          cnt_q   <= '0;
        end else begin
          acc_q <= acc_q | ((BytesPerResult*8)'(cmd_i.emit_byte) << (cnt_q * 8));
          cnt_q <= cnt_q + PW'(1);
        end
      end
    end
  end

  assign sts_o.opt_done  = (opt_idx_q == 4'(xafp_pkg::OptBytes - 1));
  assign sts_o.pay_done  = ((AW+1)'(rd_idx_q) >= (AW+1)'(fill_i));
  assign sts_o.pay_esc   = xafp_pkg::needs_escape(rd_q);
  assign sts_o.pay_byte  = rd_q;
  assign sts_o.opt_byte  = opt_byte;
  assign sts_o.csum      = sum_q;
  assign sts_o.pack_busy = out_v_q && out_stall_i;

  assign out_valid_o     = out_v_q;
  assign frame_bytes_o   = ob_q;
  assign byte_count_o    = oc_q;
  assign last_of_frame_o = ol_q;

endmodule

/* rtl/xbee_api_frame_packer.sv */
// ----------------------------------------------------------------------------
// xbee_api_frame_packer
// gathers telemetry messages and sends them as transmit-request frames
// ----------------------------------------------------------------------------
// in channel: one request per payload byte or millisecond tick, valid/stall.
// out channel: up to eight frame bytes per request, earliest byte lowest,
//   last_of_frame_o marks the request carrying the checksum.
// cfg channel: valid/ready write of register index and data, taken when idle.
// a tick or a following message byte that causes no frame is accepted, then
//   updates the message bookkeeping; a first byte is stored after its
//   bookkeeping; a message's last byte is followed by a reserve check.
// the controller serialises a frame one byte per cycle while the receiver
//   does not stall: 17 header and option bytes, payload (each stored byte
//   read then sent, plus any escape), checksum; input stalled throughout.
// when the receiver stalls the packer holds its output register and the
//   serialiser waits on it.
// reset clears all control state and loads the register defaults; the
//   payload memory is not cleared.
// ----------------------------------------------------------------------------
`include "xbee_api_frame_packer_macros.svh"

module xbee_api_frame_packer #(
  parameter int unsigned PayloadBytes   = xafp_pkg::PayloadBytesDef,
  parameter int unsigned BytesPerResult = xafp_pkg::BytesPerResultDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  msg_length_i,
  input  logic        first_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] frame_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        last_of_frame_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(PayloadBytes);
  localparam int unsigned CW = $clog2(PayloadBytes + 1);

  logic [7:0]  frame_id_q;
  logic [63:0] addr64_q;
  logic [15:0] addr16_q;
  logic [7:0]  radius_q;
  logic [7:0]  txopts_q;
  logic [15:0] timeout_q;
  logic [5:0]  thresh_q;

  logic [CW-1:0] fill_q;
  logic [7:0]    left_q, total_q;
  logic          drop_q;
  logic [15:0]   ticks_q;

  // captured request
  logic       pend_q;
  logic       p_kind_q, p_first_q;
  logic [7:0] p_data_q, p_len_q;

  // work still due after a flush or a first byte's bookkeeping
  xafp_pkg::after_e after_q;
  logic       reserve_q;

  xafp_pkg::cmd_t cmd;
  xafp_pkg::sts_t sts;
  logic busy, done, start;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0] len16;

  assign in_stall_o  = pend_q || busy || (after_q != xafp_pkg::AFT_NONE) || reserve_q;
  assign cfg_ready_o = !in_stall_o;
  assign len16       = 16'd14 + 16'(fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_id_q <= 8'h00;
      addr64_q   <= 64'h0000_0000_0000_ffff;
      addr16_q   <= 16'hfffe;
      radius_q   <= 8'h00;
      txopts_q   <= 8'h43;
      timeout_q  <= 16'd32;
      thresh_q   <= 6'd20;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        xafp_pkg::RegFrameId:   frame_id_q <= cfg_data_i[7:0];
        xafp_pkg::RegAddr64:    addr64_q   <= cfg_data_i;
        xafp_pkg::RegAddr16:    addr16_q   <= cfg_data_i[15:0];
        xafp_pkg::RegRadius:    radius_q   <= cfg_data_i[7:0];
        xafp_pkg::RegTxOpts:    txopts_q   <= cfg_data_i[7:0];
        xafp_pkg::RegTimeout:   timeout_q  <= cfg_data_i[15:0];
        xafp_pkg::RegThreshold: thresh_q   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      p_kind_q  <= kind_i;
      p_first_q <= first_of_message_i;
      p_data_q  <= data_byte_i;
      p_len_q   <= msg_length_i;
    end
  end

  // message bookkeeping; start and stores decided from the captured request
  logic [8:0] pos;
  always_comb begin
    start   = 1'b0;
    wr_en   = 1'b0;
    pos     = 9'(fill_q) + 9'(total_q) - 9'(left_q);
    wr_addr = pos[AW-1:0];
    if (!busy) begin
      if (reserve_q) begin
        start = ((CW+1)'(PayloadBytes) - (CW+1)'(fill_q)) < (CW+1)'(thresh_q);
      end else if (after_q == xafp_pkg::AFT_STORE) begin
        wr_en   = !drop_q && (pos < 9'(PayloadBytes));
      end else if (pend_q && p_kind_q) begin
        start = (left_q == 8'd0) && (fill_q != '0) &&
                (((ticks_q == 16'hffff) ? ticks_q : ticks_q + 16'd1) > timeout_q);
      end else if (pend_q && p_first_q && (p_len_q != 8'd0) &&
                   (9'(p_len_q) < 9'(PayloadBytes)) &&
                   ((9'(fill_q) + 9'(p_len_q)) >= 9'(PayloadBytes))) begin
        start = 1'b1;
      end else if (pend_q && !p_first_q && (left_q != 8'd0)) begin
        wr_en   = !drop_q && (pos < 9'(PayloadBytes));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      left_q    <= '0;
      total_q   <= '0;
      drop_q    <= 1'b0;
      ticks_q   <= '0;
      pend_q    <= 1'b0;
      after_q   <= xafp_pkg::AFT_NONE;
      reserve_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) pend_q <= 1'b1;
      if (done) begin
        fill_q <= '0;
        if (after_q == xafp_pkg::AFT_CLR_TICKS) begin
          ticks_q <= '0;
          after_q <= xafp_pkg::AFT_NONE;
        end
      end else if (!busy) begin
        if (reserve_q) begin
          // start fires a flush, otherwise nothing to do
          reserve_q <= 1'b0;
        end else if (after_q == xafp_pkg::AFT_STORE) begin
          after_q <= xafp_pkg::AFT_NONE;
          left_q  <= left_q - 8'd1;
          if (left_q == 8'd1) begin
            if (drop_q) drop_q <= 1'b0;
            else begin
              fill_q    <= fill_q + CW'(total_q);
              reserve_q <= 1'b1;
            end
          end
        end else if (pend_q) begin
          pend_q <= 1'b0;
          if (p_kind_q) begin
            if (ticks_q != 16'hffff) ticks_q <= ticks_q + 16'd1;
            if (start) after_q <= xafp_pkg::AFT_CLR_TICKS;
          end else if (p_first_q) begin
            drop_q <= 1'b0;
            left_q <= 8'd0;
            if (fill_q == '0) ticks_q <= '0;
            if (p_len_q == 8'd0) begin
              reserve_q <= 1'b1;
            end else begin
              drop_q  <= (9'(p_len_q) >= 9'(PayloadBytes));
              left_q  <= p_len_q;
              total_q <= p_len_q;
              after_q <= xafp_pkg::AFT_STORE;
            end
          end else if (left_q != 8'd0) begin
            left_q <= left_q - 8'd1;
            if (left_q == 8'd1) begin
              if (drop_q) drop_q <= 1'b0;
              else begin
                fill_q    <= fill_q + CW'(total_q);
                reserve_q <= 1'b1;
              end
            end
          end
        end
      end
    end
  end

  xafp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .len_hi_i (len16[15:8]),
    .len_lo_i (len16[7:0]),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done)
  );

  xafp_datapath #(
    .PayloadBytes   (PayloadBytes),
    .BytesPerResult (BytesPerResult)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_en_i         (wr_en),
    .wr_addr_i       (wr_addr),
    .wr_data_i       (p_data_q),
    .fill_i          (fill_q),
    .frame_id_i      (frame_id_q),
    .addr64_i        (addr64_q),
    .addr16_i        (addr16_q),
    .radius_i        (radius_q),
    .txopts_i        (txopts_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_bytes_o   (frame_bytes_o),
    .byte_count_o    (byte_count_o),
    .last_of_frame_o (last_of_frame_o)
  );

  `XAFP_ASSERT(a_fill_range, fill_q <= CW'(PayloadBytes), "fill count beyond buffer")
  `XAFP_ASSERT(a_no_accept_busy, !(in_valid_i && !in_stall_o && busy),
               "request accepted during frame")
  `XAFP_ASSERT_NEXT(a_start_busy, start && !busy, busy, "frame start did not take")
  `XAFP_ASSERT(a_drop_no_write, !(wr_en && drop_q), "write while dropping message")

endmodule
